// ----- sv/irpde_pkg.sv -----
`timescale 1ns / 1ps

package irpde_pkg;

  // Default width of every duration register and result duration
  localparam int DURATION_BITS_DEF = 20;

  // Duration register file
  localparam int NUM_REGS  = 7;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HDR_MARK   = 3'd0,
    REG_HDR_SPACE  = 3'd1,
    REG_BIT_MARK   = 3'd2,
    REG_ONE_SPACE  = 3'd3,
    REG_ZERO_SPACE = 3'd4,
    REG_END_MARK   = 3'd5,
    REG_END_SPACE  = 3'd6
  } reg_idx_t;

  // Emission step within one byte's run; even steps are marks, odd are spaces
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_HDR_MARK  = 5'd0;
  localparam step_t STEP_HDR_SPACE = 5'd1;
  localparam step_t STEP_FIRST_BIT = 5'd2;
  localparam step_t STEP_LAST_BIT  = 5'd17;
  localparam step_t STEP_END_MARK  = 5'd18;
  localparam step_t STEP_END_SPACE = 5'd19;

endpackage

// ----- sv/irpde_cfg_regs.sv -----
`timescale 1ns / 1ps

module irpde_cfg_regs #(
  parameter int DURATION_BITS = irpde_pkg::DURATION_BITS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               cfg_we,
  input  logic [irpde_pkg::REG_IDX_W-1:0]                    cfg_index,
  input  logic [DURATION_BITS-1:0]                           cfg_data,
  output logic [irpde_pkg::NUM_REGS-1:0][DURATION_BITS-1:0]  regs
);
  import irpde_pkg::*;

  logic [NUM_REGS-1:0][DURATION_BITS-1:0] regs_r;

  // Write the addressed duration; drop writes past the last register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (cfg_we && (cfg_index <= REG_END_SPACE)) begin
      regs_r[cfg_index] <= cfg_data;
    end
  end

  assign regs = regs_r;

endmodule

// ----- sv/ir_pulse_distance_encoder_core.sv -----
`timescale 1ns / 1ps

// Pulse-distance IR encoder. Each accepted word (one frame byte with start and
// end flags) produces a run of 16 durations, plus 2 for a header when
// frame_start is set and 2 for a trailer when frame_end is set. A step counter
// walks the run and the single output register releases one duration per
// cycle unless out_stall holds it. The next byte is taken in the cycle that
// emits the current byte's final duration, so runs follow without gaps.
// Durations are read live from the configuration registers, which the user
// must write through cfg_we/cfg_index/cfg_data only while the block is idle;
// the block does not enforce this. Writes to an index above six are ignored.
// The duration registers, busy flag and output valid reset to zero.
module ir_pulse_distance_encoder_core #(
  parameter int DURATION_BITS = irpde_pkg::DURATION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [irpde_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [DURATION_BITS-1:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_frame_start,
  input  logic                              in_frame_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [DURATION_BITS-1:0]          out_duration,
  output logic                              out_is_mark,
  output logic                              out_last_of_run
);
  import irpde_pkg::*;

  logic [NUM_REGS-1:0][DURATION_BITS-1:0] regs;

  irpde_cfg_regs #(
    .DURATION_BITS (DURATION_BITS)
  ) u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  logic        busy_r, busy_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        end_r, end_nxt;
  step_t       step_r, step_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [DURATION_BITS-1:0] out_duration_r, out_duration_nxt;
  logic                     out_is_mark_r, out_is_mark_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     out_adv;
  logic                     emit;
  logic                     last_step;
  logic                     in_acc;
  step_t                    bit_ofs;
  logic [2:0]               bit_idx;
  logic [DURATION_BITS-1:0] dur_sel;

  // Handshake: output register frees up, current run ends, next word enters
  assign out_adv   = !out_valid_r || !out_stall;
  assign emit      = busy_r && out_adv;
  assign last_step = (step_r == (end_r ? STEP_END_SPACE : STEP_LAST_BIT));
  assign in_stall  = busy_r && !(out_adv && last_step);
  assign in_acc    = in_valid && !in_stall;

  // Pick the duration for the current step
  assign bit_ofs = step_r - STEP_FIRST_BIT;
  assign bit_idx = bit_ofs[3:1];

  always_comb begin
    case (step_r)
      STEP_HDR_MARK:  dur_sel = regs[REG_HDR_MARK];
      STEP_HDR_SPACE: dur_sel = regs[REG_HDR_SPACE];
      STEP_END_MARK:  dur_sel = regs[REG_END_MARK];
      STEP_END_SPACE: dur_sel = regs[REG_END_SPACE];
      default: begin
        if (!step_r[0]) begin
          dur_sel = regs[REG_BIT_MARK];
        end else if (byte_r[bit_idx]) begin
          dur_sel = regs[REG_ONE_SPACE];
        end else begin
          dur_sel = regs[REG_ZERO_SPACE];
        end
      end
    endcase
  end

  // Load a new word, advance the step, or go idle after the final step
  always_comb begin
    busy_nxt = busy_r;
    byte_nxt = byte_r;
    end_nxt  = end_r;
    step_nxt = step_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
      byte_nxt = in_data_byte;
      end_nxt  = in_frame_end;
      step_nxt = in_frame_start ? STEP_HDR_MARK : STEP_FIRST_BIT;
    end else if (emit && last_step) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      step_nxt = step_r + step_t'(1);
    end
  end

  // Fill the output register on emit, drop it once taken
  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_duration_nxt = out_duration_r;
    out_is_mark_nxt  = out_is_mark_r;
    out_last_nxt     = out_last_r;
    if (emit) begin
      out_valid_nxt    = 1'b1;
      out_duration_nxt = dur_sel;
      out_is_mark_nxt  = !step_r[0];
      out_last_nxt     = last_step;
    end else if (out_adv) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r         <= byte_nxt;
    end_r          <= end_nxt;
    step_r         <= step_nxt;
    out_duration_r <= out_duration_nxt;
    out_is_mark_r  <= out_is_mark_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_duration    = out_duration_r;
  assign out_is_mark     = out_is_mark_r;
  assign out_last_of_run = out_last_r;

endmodule

// ----- sv/irpde_checker.sv -----
`timescale 1ns / 1ps

module irpde_checker #(
  parameter int DURATION_BITS = irpde_pkg::DURATION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [DURATION_BITS-1:0] out_duration,
  input  logic                     out_is_mark,
  input  logic                     out_last_of_run
);
  import irpde_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_duration) && $stable(out_is_mark) &&
       $stable(out_last_of_run)))
    else $error("stalled result word changed or dropped");

  // Every run closes on a space
  a_run_ends_space: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |-> !out_is_mark)
    else $error("run ended on a mark");

  // Come out of reset ready for a word
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // An accepted word is followed by a valid result word
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ##1 out_valid)
    else $error("no result after accepted word");

endmodule

bind ir_pulse_distance_encoder_core irpde_checker #(
  .DURATION_BITS (DURATION_BITS)
) u_irpde_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_duration    (out_duration),
  .out_is_mark     (out_is_mark),
  .out_last_of_run (out_last_of_run)
);

// ----- sim/ir_pulse_distance_encoder_core_test.sv -----
`timescale 1ns / 1ps

module ir_pulse_distance_encoder_core_test;
  import irpde_pkg::*;

  localparam int DUR_W = DURATION_BITS_DEF;
  localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};
  localparam logic [REG_IDX_W-1:0] IDX_UNMAPPED = 3'd7;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             is_mark;
    logic             last;
  } pulse_t;

  typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // Shadow the duration registers and predict the mark/space run of each byte
  class pulse_scoreboard;
    logic [DUR_W-1:0] dur_reg [NUM_REGS];
    pulse_t expected_pulses[$];
    int mismatches;
    int checked;

    function new();
      foreach (dur_reg[i]) dur_reg[i] = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_duration(logic [REG_IDX_W-1:0] idx, logic [DUR_W-1:0] val);
      // drop writes to the unmapped index
      if (idx < NUM_REGS) dur_reg[idx] = val;
    endfunction

    function void note_byte(logic [7:0] data, logic start, logic stop);
      pulse_t run[$];
      if (start) begin
        run.push_back('{dur_reg[REG_HDR_MARK], 1'b1, 1'b0});
        run.push_back('{dur_reg[REG_HDR_SPACE], 1'b0, 1'b0});
      end
      // least significant bit goes out first
      for (int b = 0; b < 8; b++) begin
        run.push_back('{dur_reg[REG_BIT_MARK], 1'b1, 1'b0});
        if (data[b]) run.push_back('{dur_reg[REG_ONE_SPACE], 1'b0, 1'b0});
        else run.push_back('{dur_reg[REG_ZERO_SPACE], 1'b0, 1'b0});
      end
      if (stop) begin
        run.push_back('{dur_reg[REG_END_MARK], 1'b1, 1'b0});
        run.push_back('{dur_reg[REG_END_SPACE], 1'b0, 1'b0});
      end
      run[run.size()-1].last = 1'b1;
      foreach (run[i]) expected_pulses.push_back(run[i]);
    endfunction

    function void check_pulse(logic [DUR_W-1:0] dur, logic mark, logic last);
      pulse_t want;
      checked++;
      if (expected_pulses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected duration %h mark %b last %b", $time, dur, mark, last);
        return;
      end
      want = expected_pulses.pop_front();
      if (want.duration !== dur || want.is_mark !== mark || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected duration %h mark %b last %b, got %h %b %b",
                   $time, want.duration, want.is_mark, want.last, dur, mark, last);
      end
    endfunction

    function int outstanding();
      return expected_pulses.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_data_byte;
  logic in_frame_start;
  logic in_frame_end;
  logic out_valid;
  logic out_stall;
  logic [DUR_W-1:0] out_duration;
  logic out_is_mark;
  logic out_last_of_run;

  pulse_scoreboard pulses = new();
  logic [DUR_W-1:0] setting [NUM_REGS];
  bit hold_off_req = 0;
  bit quiet_rx = 0;
  int burst_left = 0;
  int bytes_taken = 0;
  int settings_used = 0;

  ir_pulse_distance_encoder_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_frame_start(in_frame_start),
    .in_frame_end(in_frame_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_duration(out_duration),
    .out_is_mark(out_is_mark),
    .out_last_of_run(out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("ir_pulse_distance_encoder_core_test: FAIL");
    $finish;
  end

  // Observe register writes and both handshakes on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) pulses.set_duration(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        pulses.note_byte(in_data_byte, in_frame_start, in_frame_end);
        bytes_taken++;
      end
      if (out_valid && !out_stall)
        pulses.check_pulse(out_duration, out_is_mark, out_last_of_run);
    end
  end

  // Stall the result channel by mode, or hold off for a long stretch on request
  initial begin
    rx_mode_t rx_mode;
    int mode_left;
    rx_mode = RX_FLOW;
    mode_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          rx_mode = quiet_rx ? RX_FLOW : rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (rx_mode)
          RX_FLOW: out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Load every duration register from the setting array
  task automatic apply_setting();
    for (int i = 0; i < NUM_REGS; i++) write_reg(reg_idx_t'(i), setting[i]);
    // poke the unmapped index too; it must change nothing
    if ($urandom_range(0, 1)) write_reg(IDX_UNMAPPED, DUR_W'($urandom));
    settings_used++;
  endtask

  // Offer one word and hold it until the block takes it
  task automatic send_byte(input logic [7:0] data, input logic start, input logic stop);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_frame_start <= start;
    in_frame_end <= stop;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drop_valid(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Send in bursts with random gaps between them
  task automatic paced_send(input logic [7:0] data, input logic start, input logic stop,
                            input bit with_gaps);
    send_byte(data, start, stop);
    if (with_gaps) begin
      if (burst_left <= 0) begin
        drop_valid($urandom_range(1, 8));
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
  endtask

  // Wait for every expected duration, then let the block settle
  task automatic drain();
    drop_valid(1);
    while (pulses.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DUR_MAX;
      2: return DUR_W'($urandom_range(1, 255));
      default: return DUR_W'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames of one to six bytes, plus loose bytes
  task automatic send_frames(input int count, input bit with_gaps);
    int sent;
    int frame_len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) != 0) begin
        frame_len = $urandom_range(1, 6);
        for (int k = 0; k < frame_len && sent < count; k++) begin
          paced_send(8'($urandom_range(0, 255)), k == 0, k == frame_len - 1, with_gaps);
          sent++;
        end
      end else begin
        paced_send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), with_gaps);
        sent++;
      end
    end
  endtask

  task automatic random_setting();
    for (int i = 0; i < NUM_REGS; i++) setting[i] = pick_duration();
    apply_setting();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_frame_start = 1'b0;
    in_frame_end = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // registers still at reset: zero durations go out as they are
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0);
    drain();

    // distinct extreme values so a wrong register shows up
    setting[REG_HDR_MARK] = DUR_MAX;
    setting[REG_HDR_SPACE] = '0;
    setting[REG_BIT_MARK] = 20'h00001;
    setting[REG_ONE_SPACE] = 20'h80000;
    setting[REG_ZERO_SPACE] = 20'h7FFFF;
    setting[REG_END_MARK] = 20'h55555;
    setting[REG_END_SPACE] = 20'hAAAAA;
    apply_setting();
    write_reg(IDX_UNMAPPED, DUR_MAX);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b1, 1'b1);
    // header again with no end in between
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b1);
    send_byte(8'hC3, 1'b0, 1'b0);
    // end without a start
    send_byte(8'h0F, 1'b0, 1'b1);
    send_byte(8'hF0, 1'b1, 1'b1);
    drain();

    // every register at its maximum
    foreach (setting[i]) setting[i] = DUR_MAX;
    apply_setting();
    send_byte(8'h55, 1'b1, 1'b1);
    send_byte(8'hAA, 1'b0, 1'b0);
    drain();

    // random settings with bursty traffic
    random_setting();
    send_frames(59, 1'b1);
    drain();

    // hold the receiver off while the sender keeps offering words
    random_setting();
    @(posedge clk);
    hold_off_req = 1;
    send_frames(40, 1'b0);
    // pause until everything has come out, then carry on
    drop_valid(1);
    while (pulses.outstanding() != 0) @(posedge clk);
    send_frames(19, 1'b1);
    drain();

    // a stretch with no idling on either side
    quiet_rx = 1;
    random_setting();
    send_frames(59, 1'b0);
    drain();
    quiet_rx = 0;

    random_setting();
    send_frames(59, 1'b1);
    drain();

    random_setting();
    send_frames(59, 1'b1);
    drain();

    $display("Encoded %0d bytes into %0d checked durations under %0d register settings,",
             bytes_taken, pulses.checked, settings_used);
    $display("with bursty input, random output stalls and a long output hold-off.");
    if (pulses.mismatches == 0 && pulses.outstanding() == 0) begin
      $display("ir_pulse_distance_encoder_core_test: PASS");
    end else begin
      $display("%0d mismatches", pulses.mismatches);
      $display("ir_pulse_distance_encoder_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/irpde_pkg.sv
sv/irpde_cfg_regs.sv
sv/ir_pulse_distance_encoder_core.sv
sv/irpde_checker.sv
sim/ir_pulse_distance_encoder_core_test.sv
